/* hw/rtl/ulpt_pkg.sv */
// ulpt_pkg: shared types and constants for the UDP port listener table.
// No dependencies; imported by ulpt_cell and udp_port_listener_table_core.
package ulpt_pkg;

    localparam int SLOT_COUNT   = 128;
    localparam int IDX_W        = 7;
    localparam int HEADER_BYTES = 8;

    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_HEADER = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    localparam logic [2:0] ST_OPENED    = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_MALFORMED = 3'd5;
    localparam logic [2:0] ST_PENDING   = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    typedef struct packed {
        logic [1:0]       operation;
        logic [15:0]      port;
        logic [15:0]      sender_port;
        logic [15:0]      length_field;
        logic [31:0]      buffer_address;
        logic [15:0]      capacity;
        logic [IDX_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] slot_index;
        logic [31:0]      target_address;
        logic [15:0]      copy_length;
        logic [15:0]      remote_port;
    } rsp_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             run;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [31:0]      hit_buffer;
        logic [15:0]      hit_capacity;
        logic             poll_valid;
        logic [15:0]      poll_sender;
    } link_t;

    // Table update broadcast to all cells at the end of a transaction
    typedef struct packed {
        logic             open;
        logic             deliver;
        logic [IDX_W-1:0] idx;
    } commit_t;

endpackage

/* hw/rtl/ulpt_cell.sv */
// ulpt_cell: one listener slot plus one stage of the search chain.
// Depends on ulpt_pkg.
module ulpt_cell
    import ulpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  req_t             req,
    input  commit_t          commit,
    input  link_t            link_in,
    output link_t            link_out
);

    logic        valid_reg;
    logic [15:0] port_reg;
    logic [31:0] buffer_reg;
    logic [15:0] capacity_reg;
    logic [15:0] sender_reg;
    link_t       link_reg;
    link_t       link_next;
    logic        match;
    logic        selected;

    assign match    = valid_reg && (port_reg == req.port);
    assign selected = (commit.idx == cell_index);

    always_comb
    begin
        link_next = link_in;
        if (match && !link_in.hit)
        begin
            link_next.hit          = 1'b1;
            link_next.hit_idx      = cell_index;
            link_next.hit_buffer   = buffer_reg;
            link_next.hit_capacity = capacity_reg;
        end
        if (!valid_reg && !link_in.free)
        begin
            link_next.free     = 1'b1;
            link_next.free_idx = cell_index;
        end
        if (req.slot == cell_index)
        begin
            link_next.poll_valid  = valid_reg;
            link_next.poll_sender = valid_reg ? 16'd0 : sender_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            link_reg  <= '0;
        end
        else
        begin
            link_reg <= link_next;
            if (selected && commit.open)
                valid_reg <= 1'b1;
            else if (selected && commit.deliver)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (selected && commit.open)
        begin
            port_reg     <= req.port;
            buffer_reg   <= req.buffer_address;
            capacity_reg <= req.capacity;
        end
        if (selected && commit.deliver)
            sender_reg <= req.sender_port;
    end

    assign link_out = link_reg;

endmodule

/* hw/rtl/udp_port_listener_table_core.sv */
// udp_port_listener_table_core: listener slot table built as a chain of cells.
// Depends on ulpt_pkg and ulpt_cell.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_item  (req_t)
//   out     | output    | out_valid / out_ready| out_item (rsp_t)
//
// Each transaction walks a search token through all SLOT_COUNT cells, one cell
// per cycle, then commits at most one table update. The next transaction is
// taken only after that commit.
// Reset clears every slot's valid bit and the chain.
// A new transaction is taken while an earlier result still waits in the output
// register; a stalled output holds only the commit of the following one.
module udp_port_listener_table_core
    import ulpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_item
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       start_reg;
    req_t       req_reg;
    link_t      end_reg;
    rsp_t       out_reg;
    logic       out_valid_reg;
    rsp_t       rsp_next;
    commit_t    commit;
    logic       out_free;
    logic       accept;
    logic [15:0] payload_len;
    link_t      chain_head;

    link_t chain_link [0:SLOT_COUNT];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        chain_head     = '0;
        chain_head.run = start_reg;
    end

    assign chain_link[0] = chain_head;

    genvar k;
    generate
        for (k = 0; k < SLOT_COUNT; k++)
        begin : g_cell
            ulpt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_index(IDX_W'(k)),
                .req       (req_reg),
                .commit    (commit),
                .link_in   (chain_link[k]),
                .link_out  (chain_link[k+1])
            );
        end
    endgenerate

    assign payload_len = req_reg.length_field - 16'(HEADER_BYTES);

    // Result and table update from the finished token
    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ST_IGNORED;
        commit          = '0;
        unique case (req_reg.operation)
            OP_OPEN:
            begin
                if (end_reg.hit)
                begin
                    rsp_next.status     = ST_BUSY;
                    rsp_next.slot_index = end_reg.hit_idx;
                end
                else if (end_reg.free)
                begin
                    rsp_next.status     = ST_OPENED;
                    rsp_next.slot_index = end_reg.free_idx;
                    commit.open         = 1'b1;
                    commit.idx          = end_reg.free_idx;
                end
                else
                    rsp_next.status = ST_FULL;
            end
            OP_HEADER:
            begin
                if (end_reg.hit)
                begin
                    rsp_next.slot_index = end_reg.hit_idx;
                    if (req_reg.length_field < 16'(HEADER_BYTES))
                        rsp_next.status = ST_MALFORMED;
                    else
                    begin
                        rsp_next.status         = ST_DELIVERED;
                        rsp_next.target_address = end_reg.hit_buffer;
                        rsp_next.copy_length    = (payload_len > end_reg.hit_capacity) ?
                                                  end_reg.hit_capacity : payload_len;
                        rsp_next.remote_port    = req_reg.sender_port;
                        commit.deliver          = 1'b1;
                        commit.idx              = end_reg.hit_idx;
                    end
                end
            end
            OP_POLL:
            begin
                rsp_next.slot_index  = req_reg.slot;
                rsp_next.status      = end_reg.poll_valid ? ST_PENDING : ST_DONE;
                rsp_next.remote_port = end_reg.poll_sender;
            end
            default:
                rsp_next.status = ST_IGNORED;
        endcase
        if (state_reg != S_FINISH || !out_free)
            commit = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_SCAN;
            S_SCAN:   if (chain_link[SLOT_COUNT].run) state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (state_reg == S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_item;
        if (state_reg == S_SCAN && chain_link[SLOT_COUNT].run)
            end_reg <= chain_link[SLOT_COUNT];
        if (state_reg == S_FINISH && out_free)
            out_reg <= rsp_next;
    end

    // The token only reaches the end of the chain while a search is pending
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_link[SLOT_COUNT].run |-> state_reg == S_SCAN)
        else $error("search token left the chain outside a scan");

    // Any table update comes with a result in the output register
    a_commit_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (commit.open || commit.deliver) |=> out_valid_reg)
        else $error("table update without a result");

    // Only one update kind per transaction
    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit.open && commit.deliver))
        else $error("open and deliver committed together");

    // No new transaction while a token is in the chain
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == S_SCAN && !in_ready)
        else $error("input accepted during a scan");

endmodule

/* tb/tb_udp_port_listener_table_core.sv */
// tb_udp_port_listener_table_core: self-checking bench for the UDP listener slot table.
// It keeps a shadow of the slot table, predicts each result and compares it with the block.
// Depends on ulpt_pkg and udp_port_listener_table_core.
module tb_udp_port_listener_table_core;
    import ulpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         POOL_SIZE  = 12;
    localparam int         WORK_ITEMS = 1550;
    localparam int         MAX_REPORTS = 100;
    localparam longint     CYCLE_LIMIT = 4000000;

    // Shadow of the slot table; also holds the queue of results still owed by the block
    class listener_table_tracker;
        bit          slot_live[SLOT_COUNT];
        bit          sender_seen[SLOT_COUNT];
        logic [15:0] slot_port[SLOT_COUNT];
        logic [31:0] slot_buffer[SLOT_COUNT];
        logic [15:0] slot_capacity[SLOT_COUNT];
        logic [15:0] slot_sender[SLOT_COUNT];
        rsp_t        rsp_due[$];
        int          faults;

        function new();
            faults = 0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_live[k]     = 1'b0;
                sender_seen[k]   = 1'b0;
                slot_port[k]     = '0;
                slot_buffer[k]   = '0;
                slot_capacity[k] = '0;
                slot_sender[k]   = '0;
            end
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int k = 0; k < SLOT_COUNT; k++)
                n += slot_live[k];
            return n;
        endfunction

        function int port_owner(logic [15:0] p);
            for (int k = 0; k < SLOT_COUNT; k++)
                if (slot_live[k] && slot_port[k] == p)
                    return k;
            return -1;
        endfunction

        // A done slot that never got a header has no sender on record: keep polls off it
        function bit pollable(int k);
            return slot_live[k] || sender_seen[k];
        endfunction

        // Accepted request: update the shadow table and queue the result it owes
        function logic [2:0] note_request(req_t r);
            rsp_t o;
            int   hit;
            int   free_slot;
            int   payload;
            o = '0;
            o.status = ST_IGNORED;
            case (r.operation)
                OP_OPEN:
                begin
                    hit = port_owner(r.port);
                    if (hit >= 0)
                    begin
                        o.status = ST_BUSY;
                        o.slot_index = IDX_W'(hit);
                    end
                    else
                    begin
                        o.status = ST_FULL;
                        free_slot = -1;
                        for (int k = 0; k < SLOT_COUNT && free_slot < 0; k++)
                            if (!slot_live[k])
                                free_slot = k;
                        if (free_slot >= 0)
                        begin
                            slot_live[free_slot]     = 1'b1;
                            slot_port[free_slot]     = r.port;
                            slot_buffer[free_slot]   = r.buffer_address;
                            slot_capacity[free_slot] = r.capacity;
                            o.status = ST_OPENED;
                            o.slot_index = IDX_W'(free_slot);
                        end
                    end
                end
                OP_HEADER:
                begin
                    hit = port_owner(r.port);
                    if (hit >= 0)
                    begin
                        o.slot_index = IDX_W'(hit);
                        if (r.length_field < HEADER_BYTES)
                            o.status = ST_MALFORMED;
                        else
                        begin
                            payload = int'(r.length_field) - HEADER_BYTES;
                            if (payload > int'(slot_capacity[hit]))
                                payload = int'(slot_capacity[hit]);
                            slot_sender[hit] = r.sender_port;
                            sender_seen[hit] = 1'b1;
                            slot_live[hit]   = 1'b0;
                            o.status         = ST_DELIVERED;
                            o.target_address = slot_buffer[hit];
                            o.copy_length    = payload[15:0];
                            o.remote_port    = r.sender_port;
                        end
                    end
                end
                OP_POLL:
                begin
                    o.slot_index = r.slot;
                    if (int'(r.slot) < SLOT_COUNT)
                    begin
                        if (slot_live[r.slot])
                            o.status = ST_PENDING;
                        else
                        begin
                            o.status = ST_DONE;
                            o.remote_port = slot_sender[r.slot];
                        end
                    end
                    else
                        o.status = ST_DONE;
                end
                default:
                    o.status = ST_IGNORED;
            endcase
            rsp_due.push_back(o);
            return o.status;
        endfunction

        function bit field_ok(string what, logic [31:0] want, logic [31:0] got);
            if (got === want)
                return 1'b1;
            if (faults < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            return 1'b0;
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            bit   good;
            if (rsp_due.size() == 0)
            begin
                if (faults < MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: status %0d slot %0d",
                             $time, got.status, got.slot_index);
                faults++;
                return;
            end
            want = rsp_due.pop_front();
            good = field_ok("status", 32'(want.status), 32'(got.status));
            good &= field_ok("slot_index", 32'(want.slot_index), 32'(got.slot_index));
            good &= field_ok("target_address", want.target_address, got.target_address);
            good &= field_ok("copy_length", 32'(want.copy_length), 32'(got.copy_length));
            good &= field_ok("remote_port", 32'(want.remote_port), 32'(got.remote_port));
            if (!good)
                faults++;
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    req_t   in_item = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    rsp_t   out_item;

    listener_table_tracker book = new();
    logic [15:0] port_pool[POOL_SIZE];
    int          work_items = 0;
    int          bursts = 0;
    bit          calm_in = 1'b0;
    longint      cycles = 0;

    udp_port_listener_table_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            book.check_response(out_item);

    // Mostly short pauses, now and then one long enough to span a whole chain walk
    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 99) < 85)
            return port_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_cap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        if (r < 25)
            return 16'hFFFF;
        if (r < 60)
            return 16'($urandom_range(0, 64));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'($urandom_range(0, HEADER_BYTES - 1));
        if (r < 14)
            return 16'(HEADER_BYTES);
        if (r < 40)
            return 16'($urandom_range(HEADER_BYTES + 1, 80));
        if (r < 50)
            return 16'($urandom_range(16'hFFF0, 16'hFFFF));
        return 16'($urandom);
    endfunction

    task automatic issue(input logic [1:0] op, input logic [15:0] port,
                         input logic [15:0] sender, input logic [15:0] len,
                         input logic [31:0] addr, input logic [15:0] cap,
                         input logic [IDX_W-1:0] slot);
        req_t       r;
        int         gap;
        r.operation      = op;
        r.port           = port;
        r.sender_port    = sender;
        r.length_field   = len;
        r.buffer_address = addr;
        r.capacity       = cap;
        r.slot           = slot;
        in_valid <= 1'b1;
        in_item  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(book.note_request(r));
        work_items++;
        gap = idle_len(calm_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Fill every slot, hit the full and busy cases, poll the top and bottom slots, then drain most slots
    task automatic fill_and_drain();
        int guard;
        guard = 0;
        bursts++;
        while (book.live_count() < SLOT_COUNT && guard < 4 * SLOT_COUNT)
        begin
            issue(OP_OPEN, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                  rand_cap(), IDX_W'($urandom));
            guard++;
        end
        issue(OP_OPEN, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, rand_cap(),
              IDX_W'($urandom));
        issue(OP_OPEN, book.slot_port[$urandom_range(0, SLOT_COUNT - 1)], 16'($urandom),
              16'($urandom), $urandom, rand_cap(), IDX_W'($urandom));
        issue(OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
              IDX_W'(SLOT_COUNT - 1));
        issue(OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
              '0);
        for (int k = SLOT_COUNT - 1; k >= 0; k--)
        begin
            if (book.slot_live[k] && $urandom_range(0, 3) != 0)
            begin
                issue(OP_HEADER, book.slot_port[k], 16'($urandom), rand_len(), $urandom,
                      16'($urandom), IDX_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    issue(OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                          16'($urandom), IDX_W'(k));
            end
        end
    endtask

    // Output side: ready stretches broken by stalls, sometimes a long stretch without any
    initial
    begin
        int run_len;
        int hold;
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(300, 1500);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            hold = idle_len(1'b0);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial
    begin
        int          iter;
        int          r;
        int          start;
        int          pick;
        logic [15:0] p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++)
            port_pool[k] = 16'($urandom);

        // Directed: field extremes, short headers with and without listener, clipping
        issue(OP_OPEN, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, '0);
        issue(OP_OPEN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1);
        issue(OP_OPEN, 16'h0000, 16'h1111, 16'h2222, 32'h1234_5678, 16'h0010, '0);
        issue(OP_HEADER, 16'h1234, 16'h0001, 16'h0003, 32'h0, 16'h0, '0);
        issue(OP_HEADER, 16'hFFFF, 16'h0001, 16'h0007, 32'h0, 16'h0, '0);
        issue(OP_POLL, 16'h0000, 16'h0000, 16'h0000, 32'h0, 16'h0, IDX_W'(1));
        issue(OP_HEADER, 16'hFFFF, 16'hFFFF, 16'h0008, 32'h0, 16'h0, '0);
        issue(OP_POLL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, IDX_W'(1));
        issue(OP_HEADER, 16'h0000, 16'h0000, 16'hFFFF, 32'h0, 16'h0, '0);
        issue(OP_POLL, 16'h0000, 16'h0000, 16'h0000, 32'h0, 16'h0, '0);
        issue(OP_OPEN, 16'h00FF, 16'h0000, 16'h0000, 32'h0000_1000, 16'd100, '0);
        issue(OP_HEADER, 16'h00FF, 16'h8000, 16'd50, 32'h0, 16'h0, '0);
        issue(OP_OPEN, 16'h0007, 16'h0000, 16'h0000, 32'hA5A5_5A5A, 16'hFFFF, '0);
        issue(OP_HEADER, 16'h0007, 16'h7FFF, 16'hFFFF, 32'h0, 16'h0, '0);
        issue(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1);
        issue(OP_HEADER, 16'h0007, 16'h0000, 16'h0000, 32'h0, 16'h0, '0);
        issue(OP_OPEN, 16'h0009, 16'h0000, 16'h0000, 32'h0000_2000, 16'd20, '0);
        issue(OP_OPEN, 16'h000A, 16'h0000, 16'h0000, 32'h0000_3000, 16'd20, '0);
        issue(OP_HEADER, 16'h0009, 16'h0101, 16'd28, 32'h0, 16'h0, '0);
        issue(OP_HEADER, 16'h000A, 16'h0202, 16'd29, 32'h0, 16'h0, '0);

        iter = 0;
        while (work_items < WORK_ITEMS)
        begin
            if (iter % 100 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
            iter++;
            if (bursts == 0 && work_items >= 450)
                fill_and_drain();
            if (bursts == 1 && work_items >= 1050)
                fill_and_drain();
            r = $urandom_range(0, 99);
            if (r < 38)
                issue(OP_OPEN, pick_port(), 16'($urandom), 16'($urandom), $urandom, rand_cap(),
                      IDX_W'($urandom));
            else if (r < 78)
                issue(OP_HEADER, pick_port(), 16'($urandom), rand_len(), $urandom,
                      16'($urandom), IDX_W'($urandom));
            else if (r < 95)
            begin
                pick = -1;
                start = $urandom_range(0, SLOT_COUNT - 1);
                for (int n = 0; n < SLOT_COUNT && pick < 0; n++)
                    if (book.pollable((start + n) % SLOT_COUNT))
                        pick = (start + n) % SLOT_COUNT;
                if (pick >= 0)
                    issue(OP_POLL, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                          16'($urandom), IDX_W'(pick));
                else
                    issue(OP_OPEN, pick_port(), 16'($urandom), 16'($urandom), $urandom,
                          rand_cap(), IDX_W'($urandom));
            end
            else
            begin
                p = 16'($urandom);
                issue(OP_UNUSED, p, 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                      IDX_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        while (book.rsp_due.size() != 0)
            @(posedge clk);
        repeat (2 * (SLOT_COUNT + 3)) @(posedge clk);
        if (book.faults == 0 && book.rsp_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
